### rtl/mph_pkg.sv
// ----------------------------------------------------------------------------
// mph_pkg
// Shared types and constants of the mesh point hit test core: command codes,
// the pipeline tag and the constants of the corner slot decode.
// ----------------------------------------------------------------------------
`default_nettype none

package mph_pkg;

    localparam logic [1:0] CMD_VERTEX = 2'd0;
    localparam logic [1:0] CMD_CORNER = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam int SLOT_BITS   = 10;
    localparam int CORNER_BITS = 8;
    localparam int FIELD_BITS  = 16;
    localparam int COUNT_BITS  = 9;

    // slot / 3 as (slot * DIV3_MUL) >> DIV3_SHIFT, exact for any 10-bit slot
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_PW    = SLOT_BITS + 10;

    typedef struct packed {
        logic valid;
        logic last;
    } mph_tag_t;

endpackage

`default_nettype wire

### rtl/mesh_point_hit_test_core.sv
// ----------------------------------------------------------------------------
// mesh_point_hit_test_core
// Point in triangle mesh hit test over a vertex store and a corner store.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Vertex writes
// (cmd 0) and corner writes (cmd 1) complete in that cycle and never raise
// busy. A query (cmd 2) tests triangles 0 .. n-1, n = min(triangle_count,
// MAX_TRIANGLES), one triangle per clock through the corner memories, the
// vertex memories and a four-stage cross product pipeline; done pulses with
// hit as the last triangle leaves it (from idle when n is zero), and busy
// stays high until then. done is high for a single cycle, hit holds until
// the next done; the receiver cannot stall them. Unchecked by the block, the
// user must write triangle_count through cfg_we and cfg_data while it is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_point_hit_test_core #(
    parameter int MAX_VERTICES  = 256,
    parameter int MAX_TRIANGLES = 256,
    parameter int COORD_BITS    = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        cmd,
    input  wire logic [mph_pkg::SLOT_BITS-1:0]     slot,
    input  wire logic signed [mph_pkg::FIELD_BITS-1:0] coord_x,
    input  wire logic signed [mph_pkg::FIELD_BITS-1:0] coord_y,
    input  wire logic [mph_pkg::CORNER_BITS-1:0]   corner_vertex,
    input  wire logic                              cfg_we,
    input  wire logic [mph_pkg::COUNT_BITS-1:0]    cfg_data,
    output logic                                   done,
    output logic                                   hit
);
    import mph_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [TAW-1:0]        tri_reg, tri_next;
    logic [TAW-1:0]        last_tri_reg, last_tri_next;
    logic [CW-1:0]         px_reg, py_reg;
    logic                  acc_reg, acc_next;
    logic                  done_reg, done_next;
    logic                  hit_reg, hit_next;

    logic                  accept;
    logic [CW-1:0]         in_x, in_y;
    logic                  vtx_we, crn_we;
    logic [DIV3_PW-1:0]    div3_prod;
    logic [SLOT_BITS-1:0]  slot_q;
    logic [SLOT_BITS-1:0]  slot_r;
    mph_tag_t              issue_tag, mem_tag, area_tag;
    logic                  area_hit;
    logic [CW-1:0]         vx [3];
    logic [CW-1:0]         vy [3];

    if (COORD_BITS <= FIELD_BITS)
    begin : g_narrow
        assign in_x = coord_x[CW-1:0];
        assign in_y = coord_y[CW-1:0];
    end
    else
    begin : g_wide
        assign in_x = {{(CW-FIELD_BITS){1'b0}}, coord_x};
        assign in_y = {{(CW-FIELD_BITS){1'b0}}, coord_y};
    end

    assign accept    = start && !busy;
    assign vtx_we    = accept && (cmd == CMD_VERTEX) && (32'(slot) < 32'(MAX_VERTICES));
    assign crn_we    = accept && (cmd == CMD_CORNER) && (32'(slot) < 32'(3 * MAX_TRIANGLES));
    assign div3_prod = DIV3_PW'(slot) * DIV3_PW'(DIV3_MUL);
    assign slot_q    = SLOT_BITS'(div3_prod >> DIV3_SHIFT);
    assign slot_r    = slot - SLOT_BITS'(slot_q * SLOT_BITS'(3));

    assign issue_tag.valid = (state_reg == ST_ISSUE);
    assign issue_tag.last  = (state_reg == ST_ISSUE) && (tri_reg == last_tri_reg);

    always_comb
    begin
        state_next    = state_reg;
        tri_next      = tri_reg;
        last_tri_next = last_tri_reg;
        acc_next      = acc_reg;
        done_next     = 1'b0;
        hit_next      = hit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_QUERY))
                begin
                    tri_next = '0;
                    acc_next = 1'b0;
                    if (count_reg == '0)
                    begin
                        done_next = 1'b1;
                        hit_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (32'(count_reg) > 32'(MAX_TRIANGLES))
                        begin
                            last_tri_next = TAW'(MAX_TRIANGLES - 1);
                        end
                        else
                        begin
                            last_tri_next = TAW'(count_reg - COUNT_BITS'(1));
                        end
                    end
                end
            end
            ST_ISSUE:
            begin
                tri_next = tri_reg + TAW'(1);
                if (tri_reg == last_tri_reg)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (area_tag.valid && area_tag.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (area_tag.valid)
        begin
            acc_next = acc_reg || area_hit;
            if (area_tag.last)
            begin
                done_next = 1'b1;
                hit_next  = acc_reg || area_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tri_reg      <= tri_next;
        last_tri_reg <= last_tri_next;
        acc_reg      <= acc_next;
        hit_reg      <= hit_next;
        if (accept && (cmd == CMD_QUERY))
        begin
            px_reg <= in_x;
            py_reg <= in_y;
        end
    end

    mph_mesh_mem #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .COORD_BITS    (COORD_BITS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .vtx_we   (vtx_we),
        .vtx_addr (VAW'(slot)),
        .vtx_x    (in_x),
        .vtx_y    (in_y),
        .crn_we   (crn_we),
        .crn_tri  (TAW'(slot_q)),
        .crn_pos  (slot_r[1:0]),
        .crn_data (corner_vertex),
        .rd_tag   (issue_tag),
        .rd_tri   (tri_reg),
        .out_tag  (mem_tag),
        .out_x    (vx),
        .out_y    (vy)
    );

    mph_area_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_area (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (mem_tag),
        .px      (px_reg),
        .py      (py_reg),
        .vx      (vx),
        .vy      (vy),
        .tag_out (area_tag),
        .hit_out (area_hit)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign hit  = hit_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a query is still running");

    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd != CMD_QUERY)) |=> !busy)
        else $error("write transaction raised busy");

    a_pipe_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        (area_tag.valid || mem_tag.valid) |-> busy)
        else $error("triangle in flight outside a query");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (area_tag.valid && area_tag.last) |=> (done && !busy))
        else $error("last triangle did not end the query");

endmodule

`default_nettype wire

### rtl/mph_area_pipe.sv
// ----------------------------------------------------------------------------
// mph_area_pipe
// Four-stage edge cross product pipeline: corner differences, products,
// sub-areas, then the sign test that decides whether the point is inside.
// ----------------------------------------------------------------------------
`default_nettype none

module mph_area_pipe #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mph_pkg::mph_tag_t     tag_in,
    input  wire logic [COORD_BITS-1:0] px,
    input  wire logic [COORD_BITS-1:0] py,
    input  wire logic [COORD_BITS-1:0] vx [3],
    input  wire logic [COORD_BITS-1:0] vy [3],
    output mph_pkg::mph_tag_t          tag_out,
    output logic                       hit_out
);
    import mph_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int AW = PW + 1;
    localparam int BW = AW + 2;

    mph_tag_t tag_a_reg, tag_b_reg, tag_c_reg, tag_d_reg;

    logic signed [DW-1:0] abx_reg, aby_reg, acx_reg, acy_reg, apx_reg, apy_reg;
    logic signed [DW-1:0] abx_next, aby_next, acx_next, acy_next, apx_next, apy_next;

    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [PW-1:0] p0_next, p1_next, p2_next, p3_next, p4_next, p5_next;

    logic signed [AW-1:0] abc_reg, abp_reg, apc_reg;
    logic signed [AW-1:0] abc_next, abp_next, apc_next;

    logic signed [BW-1:0] pbc;
    logic                 hit_reg, hit_next;

    always_comb
    begin
        abx_next = DW'(signed'(vx[1])) - DW'(signed'(vx[0]));
        aby_next = DW'(signed'(vy[1])) - DW'(signed'(vy[0]));
        acx_next = DW'(signed'(vx[2])) - DW'(signed'(vx[0]));
        acy_next = DW'(signed'(vy[2])) - DW'(signed'(vy[0]));
        apx_next = DW'(signed'(px)) - DW'(signed'(vx[0]));
        apy_next = DW'(signed'(py)) - DW'(signed'(vy[0]));
    end

    always_comb
    begin
        p0_next = PW'(abx_reg) * PW'(acy_reg);
        p1_next = PW'(aby_reg) * PW'(acx_reg);
        p2_next = PW'(abx_reg) * PW'(apy_reg);
        p3_next = PW'(aby_reg) * PW'(apx_reg);
        p4_next = PW'(apx_reg) * PW'(acy_reg);
        p5_next = PW'(apy_reg) * PW'(acx_reg);
    end

    always_comb
    begin
        abc_next = AW'(p0_reg) - AW'(p1_reg);
        abp_next = AW'(p2_reg) - AW'(p3_reg);
        apc_next = AW'(p4_reg) - AW'(p5_reg);
    end

    always_comb
    begin
        pbc = BW'(abc_reg) - BW'(abp_reg) - BW'(apc_reg);
        if (!abc_reg[AW-1])
        begin
            hit_next = !abp_reg[AW-1] && !apc_reg[AW-1] && !pbc[BW-1];
        end
        else
        begin
            hit_next = (abp_reg[AW-1] || (abp_reg == '0))
                    && (apc_reg[AW-1] || (apc_reg == '0))
                    && (pbc[BW-1] || (pbc == '0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= tag_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        abx_reg <= abx_next;
        aby_reg <= aby_next;
        acx_reg <= acx_next;
        acy_reg <= acy_next;
        apx_reg <= apx_next;
        apy_reg <= apy_next;
        p0_reg  <= p0_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        p3_reg  <= p3_next;
        p4_reg  <= p4_next;
        p5_reg  <= p5_next;
        abc_reg <= abc_next;
        abp_reg <= abp_next;
        apc_reg <= apc_next;
        hit_reg <= hit_next;
    end

    assign tag_out = tag_d_reg;
    assign hit_out = hit_reg;

endmodule

`default_nettype wire

### rtl/mph_mesh_mem.sv
// ----------------------------------------------------------------------------
// mph_mesh_mem
// Mesh storage: one corner memory per triangle corner and one vertex memory
// copy per corner, read as a two-stage pipeline (corners, then vertices).
// ----------------------------------------------------------------------------
`default_nettype none

module mph_mesh_mem #(
    parameter  int MAX_VERTICES  = 256,
    parameter  int MAX_TRIANGLES = 256,
    parameter  int COORD_BITS    = 16,
    localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
    localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  vtx_we,
    input  wire logic [VAW-1:0]        vtx_addr,
    input  wire logic [COORD_BITS-1:0] vtx_x,
    input  wire logic [COORD_BITS-1:0] vtx_y,
    input  wire logic                  crn_we,
    input  wire logic [TAW-1:0]        crn_tri,
    input  wire logic [1:0]            crn_pos,
    input  wire logic [mph_pkg::CORNER_BITS-1:0] crn_data,
    input  wire mph_pkg::mph_tag_t     rd_tag,
    input  wire logic [TAW-1:0]        rd_tri,
    output mph_pkg::mph_tag_t          out_tag,
    output logic [COORD_BITS-1:0]      out_x [3],
    output logic [COORD_BITS-1:0]      out_y [3]
);
    import mph_pkg::*;

    localparam int CW = COORD_BITS;

    mph_tag_t tag1_reg, tag2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= rd_tag;
            tag2_reg <= tag1_reg;
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_corner
        logic [CORNER_BITS-1:0] cmem [MAX_TRIANGLES];
        logic [2*CW-1:0]        vmem [MAX_VERTICES];
        logic [CORNER_BITS-1:0] crn_reg;
        logic [2*CW-1:0]        vdata_reg;
        logic                   oor_reg;

        always_ff @(posedge clk)
        begin
            if (crn_we && (crn_pos == 2'(k)))
            begin
                cmem[crn_tri] <= crn_data;
            end
            crn_reg <= cmem[rd_tri];
        end

        always_ff @(posedge clk)
        begin
            if (vtx_we)
            begin
                vmem[vtx_addr] <= {vtx_y, vtx_x};
            end
            vdata_reg <= vmem[VAW'(crn_reg)];
            oor_reg   <= (32'(crn_reg) >= 32'(MAX_VERTICES));
        end

        assign out_x[k] = oor_reg ? '0 : vdata_reg[CW-1:0];
        assign out_y[k] = oor_reg ? '0 : vdata_reg[2*CW-1:CW];
    end

    assign out_tag = tag2_reg;

endmodule

`default_nettype wire
